// ----- hw/rtl/gvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared widths, register indexes and types for the grid circulation block.
// ----------------------------------------------------------------------------
package gvc_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_COLS_DEF  = 1024;
    localparam int VEL_WIDTH_DEF = 16;

    // Fixed geometry and field widths.
    localparam int MAX_ROWS   = 1024;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int VORT_W     = 40;
    localparam int SPACING_W  = 16;
    localparam int GEOM_W     = 11;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SIGN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SIGN    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [GEOM_W-1:0]    GRID_COLS_RST = 11'd2;
    localparam logic [GEOM_W-1:0]    GRID_ROWS_RST = 11'd2;
    localparam logic [SPACING_W-1:0] SPACING_RST   = 16'd256;

    // Result slots of one input word, in emission order.
    localparam int NUM_SLOTS = 4;
    localparam logic [1:0] SLOT_UP_J  = 2'd0;  // (r-1, c-1)
    localparam logic [1:0] SLOT_UP_C  = 2'd1;  // (r-1, c) at a row end
    localparam logic [1:0] SLOT_CUR_J = 2'd2;  // (r, c-1) in the last row
    localparam logic [1:0] SLOT_CUR_C = 2'd3;  // (r, c), the frame's last node

    // Position flags of one node word, worked out when the word is taken.
    typedef struct packed {
        logic closes;     // the word closes a cell (row and column both nonzero)
        logic top;        // the closed cell touches row 0
        logic bottom;     // the word sits in the last row
        logic row_end;    // the word sits in the last column
        logic first_col;  // the closed cell touches column 0
        logic no_carry;   // the row above has no carried sums (rows 0 and 1)
    } t_flags;

    // One result word.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VORT_W-1:0] vort;
    } t_result;

    // All result words caused by one input word.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]         mask;
        t_result [NUM_SLOTS-1:0]      slot;
    } t_res_set;

endpackage

// ----- hw/rtl/gvc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_cell
// Node counters, velocity line buffer and the loop sum of each closed cell.
// ----------------------------------------------------------------------------
module gvc_cell
    import gvc_pkg::*;
#(
    parameter  int MAX_COLS  = MAX_COLS_DEF,
    parameter  int VEL_WIDTH = VEL_WIDTH_DEF,
    localparam int COL_CW    = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1,
    localparam int SUM_W     = VEL_WIDTH + 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic [COL_CW-1:0]           i_last_col,
    input  logic [ROW_W-1:0]            i_last_row,
    input  logic                        i_x_sign,
    input  logic                        i_y_sign,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [VEL_WIDTH-1:0] i_vel_x,
    input  logic signed [VEL_WIDTH-1:0] i_vel_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [SUM_W-1:0]     o_sum,
    output logic [ROW_W-1:0]            o_row,
    output logic [COL_CW-1:0]           o_col,
    output t_flags                      o_flags
);

    logic                        accept;
    logic                        adv1;
    t_flags                      n_flags;

    logic [ROW_W-1:0]            r_row;
    logic [COL_CW-1:0]           r_col;

    // Input stage.
    logic                        r_v1;
    logic signed [VEL_WIDTH-1:0] r_vx1;
    logic signed [VEL_WIDTH-1:0] r_vy1;
    logic [ROW_W-1:0]            r_row1;
    logic [COL_CW-1:0]           r_col1;
    t_flags                      r_flags1;
    logic [2*VEL_WIDTH-1:0]      r_up_rd;

    // Neighbors from the previous word: lower-left and upper-left corners.
    logic signed [VEL_WIDTH-1:0] r_left_x;
    logic signed [VEL_WIDTH-1:0] r_left_y;
    logic signed [VEL_WIDTH-1:0] r_ul_x;
    logic signed [VEL_WIDTH-1:0] r_ul_y;

    // Sum stage.
    logic                        r_v2;
    logic signed [SUM_W-1:0]     r_sum2;
    logic [ROW_W-1:0]            r_row2;
    logic [COL_CW-1:0]           r_col2;
    t_flags                      r_flags2;

    logic signed [VEL_WIDTH-1:0] ur_x;
    logic signed [VEL_WIDTH-1:0] ur_y;
    logic signed [SUM_W-1:0]     dx;
    logic signed [SUM_W-1:0]     dy;
    logic signed [SUM_W-1:0]     n_sum;

    // Previous row of node velocities, one entry per column.
    logic [2*VEL_WIDTH-1:0]      line_mem [MAX_COLS];

    assign accept  = i_valid && o_ready;
    assign adv1    = r_v1 && (!r_v2 || i_ready);
    assign o_ready = !r_v1 || adv1;

    // Position flags of the word at the counters.
    always_comb begin
        n_flags.closes    = (r_row != '0) && (r_col != '0);
        n_flags.top       = (r_row == ROW_W'(1));
        n_flags.bottom    = (r_row == i_last_row);
        n_flags.row_end   = (r_col == i_last_col);
        n_flags.first_col = (r_col == COL_CW'(1));
        n_flags.no_carry  = (r_row < ROW_W'(2));
    end

    // Row-major node counters; a geometry write starts a new frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (r_col == i_last_col) begin
                r_col <= '0;
                r_row <= (r_row == i_last_row) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_CW'(1);
            end
        end
    end

    // Line buffer: read the upper-right corner when a word is taken, and
    // overwrite the column with this row's velocity as the word moves on.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd <= line_mem[r_col];
        end
        if (adv1) begin
            line_mem[r_col1] <= {r_vx1, r_vy1};
        end
    end

    // Input stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    // Input stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vx1    <= i_vel_x;
            r_vy1    <= i_vel_y;
            r_row1   <= r_row;
            r_col1   <= r_col;
            r_flags1 <= n_flags;
        end
    end

    assign ur_x = r_up_rd[2*VEL_WIDTH-1:VEL_WIDTH];
    assign ur_y = r_up_rd[VEL_WIDTH-1:0];

    // Loop sum around the cell, with the axis signs applied.
    always_comb begin
        dx = SUM_W'(r_left_x) + SUM_W'(r_vx1) - SUM_W'(ur_x) - SUM_W'(r_ul_x);
        dy = SUM_W'(r_vy1) + SUM_W'(ur_y) - SUM_W'(r_ul_y) - SUM_W'(r_left_y);
        n_sum = (i_x_sign ? -dx : dx) + (i_y_sign ? -dy : dy);
    end

    // Keep this word's corners as the left neighbors of the next one.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_left_x <= r_vx1;
            r_left_y <= r_vy1;
            r_ul_x   <= ur_x;
            r_ul_y   <= ur_y;
        end
    end

    // Sum stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= 1'b1;
        end else if (i_ready) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_sum2   <= n_sum;
            r_row2   <= r_row1;
            r_col2   <= r_col1;
            r_flags2 <= r_flags1;
        end
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum2;
    assign o_row   = r_row2;
    assign o_col   = r_col2;
    assign o_flags = r_flags2;

endmodule

// ----- hw/rtl/gvc_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_accum
// Scales the loop sum by the spacing and spreads it over the corner nodes.
// ----------------------------------------------------------------------------
module gvc_accum
    import gvc_pkg::*;
#(
    parameter  int MAX_COLS  = MAX_COLS_DEF,
    parameter  int VEL_WIDTH = VEL_WIDTH_DEF,
    localparam int COL_CW    = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1,
    localparam int SUM_W     = VEL_WIDTH + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [SPACING_W-1:0]    i_spacing,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [COL_CW-1:0]       i_col,
    input  t_flags                  i_flags,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_res_set                o_set
);

    localparam int PROD_W = SUM_W + SPACING_W + 1;

    logic                        adv2;
    logic                        take3;
    logic signed [PROD_W-1:0]    prod;

    // Scaled stage.
    logic                        r_v3;
    logic signed [VORT_W-1:0]    r_e;
    logic [ROW_W-1:0]            r_row3;
    logic [COL_CW-1:0]           r_col3;
    t_flags                      r_flags3;
    logic [VORT_W-1:0]           r_carry_rd;

    // Partial sums of the upper and current node of the running column,
    // and the carried sum of the last column.
    logic signed [VORT_W-1:0]    r_up;
    logic signed [VORT_W-1:0]    r_cur;
    logic signed [VORT_W-1:0]    r_carry_last;

    // Sums carried from one row to the next, one entry per column.
    logic [VORT_W-1:0]           carry_mem [MAX_COLS];

    logic                        wr_en;
    logic [COL_CW-1:0]           wr_addr;
    logic signed [VORT_W-1:0]    e_eff;
    logic signed [VORT_W-1:0]    carry_c;
    logic signed [VORT_W-1:0]    t_nw;
    logic signed [VORT_W-1:0]    t_ne;
    logic signed [VORT_W-1:0]    t_sw;
    logic signed [VORT_W-1:0]    t_se;
    logic signed [VORT_W-1:0]    up_j;
    logic signed [VORT_W-1:0]    up_c;
    logic signed [VORT_W-1:0]    cur_j;
    logic signed [VORT_W-1:0]    cur_c;
    logic [ROW_W-1:0]            row_i;
    logic [COL_CW-1:0]           col_j;

    assign take3   = r_v3 && i_ready;
    assign o_ready = !r_v3 || take3;
    assign adv2    = i_valid && o_ready;

    // Loop sum times spacing; the spacing is unsigned.
    assign prod = i_sum * $signed({1'b0, i_spacing});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv2) begin
            r_v3 <= 1'b1;
        end else if (take3) begin
            r_v3 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_e      <= VORT_W'(prod);
            r_row3   <= i_row;
            r_col3   <= i_col;
            r_flags3 <= i_flags;
        end
    end

    // Carried-sum buffer. A write to the entry being read in the same cycle
    // (two-column grids at a row change) is forwarded.
    assign wr_en   = take3 && r_flags3.closes;
    assign wr_addr = r_col3 - COL_CW'(1);

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_carry_rd <= (wr_en && (wr_addr == i_col)) ? cur_j : carry_mem[i_col];
        end
        if (wr_en) begin
            carry_mem[wr_addr] <= cur_j;
        end
    end

    // Corner weights in quarter units: 4 at grid corners, 2 on top and bottom
    // edges, 1 elsewhere.
    always_comb begin
        e_eff = r_flags3.closes ? r_e : '0;
        if (r_flags3.no_carry) begin
            carry_c = '0;
        end else if (r_flags3.row_end) begin
            carry_c = r_carry_last;
        end else begin
            carry_c = $signed(r_carry_rd);
        end

        if (r_flags3.top) begin
            t_nw = r_flags3.first_col ? (e_eff <<< 2) : (e_eff <<< 1);
            t_ne = r_flags3.row_end   ? (e_eff <<< 2) : (e_eff <<< 1);
        end else begin
            t_nw = e_eff;
            t_ne = e_eff;
        end

        if (r_flags3.bottom) begin
            t_sw = r_flags3.first_col ? (e_eff <<< 2) : (e_eff <<< 1);
            t_se = r_flags3.row_end   ? (e_eff <<< 2) : (e_eff <<< 1);
        end else begin
            t_sw = e_eff;
            t_se = e_eff;
        end

        up_j  = r_up + t_nw;
        up_c  = carry_c + t_ne;
        cur_j = r_cur + t_sw;
        cur_c = t_se;
    end

    // Column partial sums move on with every word; the last column's carried
    // sum has a register of its own.
    always_ff @(posedge i_clk) begin
        if (take3) begin
            r_up  <= up_c;
            r_cur <= cur_c;
            if (r_flags3.closes && r_flags3.row_end) begin
                r_carry_last <= cur_c;
            end
        end
    end

    // Completed nodes of this word.
    assign row_i = r_row3 - ROW_W'(1);
    assign col_j = r_col3 - COL_CW'(1);

    always_comb begin
        o_set.mask[SLOT_UP_J]  = r_flags3.closes;
        o_set.mask[SLOT_UP_C]  = r_flags3.closes && r_flags3.row_end;
        o_set.mask[SLOT_CUR_J] = r_flags3.closes && r_flags3.bottom;
        o_set.mask[SLOT_CUR_C] = r_flags3.closes && r_flags3.bottom && r_flags3.row_end;

        o_set.slot[SLOT_UP_J].row  = row_i;
        o_set.slot[SLOT_UP_J].col  = COL_W'(col_j);
        o_set.slot[SLOT_UP_J].vort = up_j;

        o_set.slot[SLOT_UP_C].row  = row_i;
        o_set.slot[SLOT_UP_C].col  = COL_W'(r_col3);
        o_set.slot[SLOT_UP_C].vort = up_c;

        o_set.slot[SLOT_CUR_J].row  = r_row3;
        o_set.slot[SLOT_CUR_J].col  = COL_W'(col_j);
        o_set.slot[SLOT_CUR_J].vort = cur_j;

        o_set.slot[SLOT_CUR_C].row  = r_row3;
        o_set.slot[SLOT_CUR_C].col  = COL_W'(r_col3);
        o_set.slot[SLOT_CUR_C].vort = cur_c;
    end

    assign o_valid = r_v3;

endmodule

// ----- hw/rtl/gvc_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_emit
// Holds the result words of one input word and sends them out one by one.
// ----------------------------------------------------------------------------
module gvc_emit
    import gvc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_res_set                 i_set,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ROW_W-1:0]         o_node_row,
    output logic [COL_W-1:0]         o_node_col,
    output logic signed [VORT_W-1:0] o_vorticity,
    output logic                     o_run_last,
    output logic                     o_frame_last
);

    logic [NUM_SLOTS-1:0]  r_mask;
    t_result [NUM_SLOTS-1:0] r_slot;

    logic [1:0]            sel;
    logic [NUM_SLOTS-1:0]  rest;
    logic                  take;
    logic                  last;
    logic                  load;

    // Lowest pending slot goes out first.
    always_comb begin
        if (r_mask[SLOT_UP_J]) begin
            sel = SLOT_UP_J;
        end else if (r_mask[SLOT_UP_C]) begin
            sel = SLOT_UP_C;
        end else if (r_mask[SLOT_CUR_J]) begin
            sel = SLOT_CUR_J;
        end else begin
            sel = SLOT_CUR_C;
        end
    end

    assign rest    = r_mask & (r_mask - NUM_SLOTS'(1));
    assign o_valid = (r_mask != '0);
    assign take    = o_valid && i_ready;
    assign last    = (rest == '0);
    assign o_ready = (r_mask == '0) || (take && last);
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (load) begin
            r_mask <= i_set.mask;
        end else if (take) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot <= i_set.slot;
        end
    end

    assign o_node_row   = r_slot[sel].row;
    assign o_node_col   = r_slot[sel].col;
    assign o_vorticity  = r_slot[sel].vort;
    assign o_run_last   = last;
    assign o_frame_last = (sel == SLOT_CUR_C);

    // The frame's last node is always the last word of its run.
    a_frame_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> o_run_last)
        else $error("frame_last word is not the last of its run");

    // Each word sent without a new load retires exactly one pending slot.
    a_one_slot_per_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !load) |=> ($countones(r_mask) + 1 == $countones($past(r_mask))))
        else $error("pending slot count did not drop by one");

    // A result set always starts with the upper-left node, and the frame's
    // last node comes only with both bottom-row and row-end neighbors.
    a_set_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> ((i_set.mask == '0) || i_set.mask[SLOT_UP_J]) &&
                 (!i_set.mask[SLOT_CUR_C] ||
                  (i_set.mask[SLOT_CUR_J] && i_set.mask[SLOT_UP_C])))
        else $error("malformed result set");

endmodule

// ----- hw/rtl/grid_vorticity_circulation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_vorticity_circulation_top
// Streaming circulation of a 2-D node grid: node velocities in, completed
// nodes with their weighted circulation out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Word
//   --------  ---------  ----------------------  ------------------------------
//   node in   input      i_valid / o_ready       i_vel_x, i_vel_y
//   result    output     o_valid / i_ready       o_node_row, o_node_col,
//                                                o_vorticity, o_run_last,
//                                                o_frame_last
//   config    input      i_cfg_wr_en (no wait)   i_cfg_index, i_cfg_data
//
// One node word is taken per cycle unless a downstream stall holds the pipe. A
// word yields up to four result words (row ends and the last row), which leave
// the single result port at one per cycle while i_ready is high. Each word
// passes the input, sum, scaled and emit registers, and output stalls back up
// through all of them. Synchronous active-low reset clears the counters and
// all stage valids; the row sums need no clearing pass, since rows 0 and 1 of
// every frame read the carried sums as zero.
// ----------------------------------------------------------------------------
module grid_vorticity_circulation_top
    import gvc_pkg::*;
#(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [VEL_WIDTH-1:0] i_vel_x,
    input  logic signed [VEL_WIDTH-1:0] i_vel_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ROW_W-1:0]            o_node_row,
    output logic [COL_W-1:0]            o_node_col,
    output logic signed [VORT_W-1:0]    o_vorticity,
    output logic                        o_run_last,
    output logic                        o_frame_last
);

    localparam int COL_CW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
    localparam int SUM_W  = VEL_WIDTH + 3;
    localparam int GEO_W  = (COL_CW + 1 > GEOM_W) ? COL_CW + 1 : GEOM_W;

    logic [GEOM_W-1:0]     r_grid_cols;
    logic [GEOM_W-1:0]     r_grid_rows;
    logic [SPACING_W-1:0]  r_spacing;
    logic                  r_x_sign;
    logic                  r_y_sign;

    logic                  restart;
    logic [GEO_W-1:0]      cols_ext;
    logic [GEO_W-1:0]      cols_eff;
    logic [GEOM_W-1:0]     rows_eff;
    logic [COL_CW-1:0]     last_col;
    logic [ROW_W-1:0]      last_row;

    logic                  sum_valid;
    logic                  sum_ready;
    logic signed [SUM_W-1:0] sum_val;
    logic [ROW_W-1:0]      sum_row;
    logic [COL_CW-1:0]     sum_col;
    t_flags                sum_flags;

    logic                  set_valid;
    logic                  set_ready;
    t_res_set              res_set;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_COLS_RST;
            r_grid_rows <= GRID_ROWS_RST;
            r_spacing   <= SPACING_RST;
            r_x_sign    <= 1'b0;
            r_y_sign    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data[GEOM_W-1:0];
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[GEOM_W-1:0];
                CFG_SPACING:   r_spacing   <= i_cfg_data[SPACING_W-1:0];
                CFG_X_SIGN:    r_x_sign    <= i_cfg_data[0];
                CFG_Y_SIGN:    r_y_sign    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A geometry write starts a new frame.
    assign restart = i_cfg_wr_en &&
                     ((i_cfg_index == CFG_GRID_COLS) || (i_cfg_index == CFG_GRID_ROWS));

    // Effective geometry, saturated to the supported range.
    always_comb begin
        cols_ext = GEO_W'(r_grid_cols);
        if (cols_ext < GEO_W'(2)) begin
            cols_eff = GEO_W'(2);
        end else if (cols_ext > GEO_W'(MAX_COLS)) begin
            cols_eff = GEO_W'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end

        if (r_grid_rows < GEOM_W'(2)) begin
            rows_eff = GEOM_W'(2);
        end else if (r_grid_rows > GEOM_W'(MAX_ROWS)) begin
            rows_eff = GEOM_W'(MAX_ROWS);
        end else begin
            rows_eff = r_grid_rows;
        end

        last_col = COL_CW'(cols_eff - GEO_W'(1));
        last_row = ROW_W'(rows_eff - GEOM_W'(1));
    end

    gvc_cell #(
        .MAX_COLS  (MAX_COLS),
        .VEL_WIDTH (VEL_WIDTH)
    ) u_cell (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_last_col (last_col),
        .i_last_row (last_row),
        .i_x_sign   (r_x_sign),
        .i_y_sign   (r_y_sign),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_vel_x    (i_vel_x),
        .i_vel_y    (i_vel_y),
        .o_valid    (sum_valid),
        .i_ready    (sum_ready),
        .o_sum      (sum_val),
        .o_row      (sum_row),
        .o_col      (sum_col),
        .o_flags    (sum_flags)
    );

    gvc_accum #(
        .MAX_COLS  (MAX_COLS),
        .VEL_WIDTH (VEL_WIDTH)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_spacing (r_spacing),
        .i_valid   (sum_valid),
        .o_ready   (sum_ready),
        .i_sum     (sum_val),
        .i_row     (sum_row),
        .i_col     (sum_col),
        .i_flags   (sum_flags),
        .o_valid   (set_valid),
        .i_ready   (set_ready),
        .o_set     (res_set)
    );

    gvc_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (set_valid),
        .o_ready      (set_ready),
        .i_set        (res_set),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_node_row   (o_node_row),
        .o_node_col   (o_node_col),
        .o_vorticity  (o_vorticity),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

endmodule
